@@ sv/ipv4_udp_header_checksum_gen_unit_assert.svh @@
// Assertion macros used by the port checker of the checksum generator.
`ifndef IPV4_UDP_HEADER_CHECKSUM_GEN_UNIT_ASSERT_SVH
`define IPV4_UDP_HEADER_CHECKSUM_GEN_UNIT_ASSERT_SVH

// Consequence checked in the same cycle as the antecedent.
`define IUHC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("checksum generator port assertion failed");

// Consequence checked in the cycle after the antecedent.
`define IUHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("checksum generator port assertion failed");

`endif

@@ sv/iuhc_pkg.sv @@
// Package with constants, types and checksum helpers of the checksum generator.
package iuhc_pkg;

    localparam int unsigned LEN_W         = 11;
    localparam int unsigned MAX_PAYLOAD   = 1472;
    localparam int unsigned UDP_HDR_BYTES = 8;
    localparam int unsigned IP_HDR_BYTES  = 20;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned CFG_DATA_W    = 32;

    localparam logic [LEN_W-1:0] MAX_COUNT   = LEN_W'(MAX_PAYLOAD);
    localparam logic [LEN_W-1:0] UDP_HDR_LEN = LEN_W'(UDP_HDR_BYTES);
    localparam logic [LEN_W-1:0] IP_UDP_HDR_LEN = LEN_W'(UDP_HDR_BYTES + IP_HDR_BYTES);
    localparam logic [LEN_W-1:0] MAX_IP_LEN  = LEN_W'(MAX_PAYLOAD + UDP_HDR_BYTES
                                                       + IP_HDR_BYTES);

    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [15:0] IP_VER_IHL_TOS = 16'h4500;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_IP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_IP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_PORT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_PORT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_TO_LIVE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IDENT        = 3'd5;

    // Register reset values.
    localparam logic [31:0] RST_SOURCE_IP    = 32'h0000_0000;
    localparam logic [31:0] RST_DEST_IP      = 32'hFFFF_FFFF;
    localparam logic [15:0] RST_SOURCE_PORT  = 16'd68;
    localparam logic [15:0] RST_DEST_PORT    = 16'd67;
    localparam logic [7:0]  RST_TIME_TO_LIVE = 8'd250;
    localparam logic [15:0] RST_IDENT        = 16'd54321;

    // Payload summary handed from the accumulator on the final byte.
    typedef struct packed {
        logic [15:0]      psum;
        logic [LEN_W-1:0] count;
        logic             overflow;
    } acc_fin_t;

    // One's-complement 16-bit add with end-around carry.
    function automatic logic [15:0] oc_add16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // Folds a plain 20-bit sum into a 16-bit one's-complement value.
    function automatic logic [15:0] fold20(input logic [19:0] s);
        logic [16:0] t;
        t = {1'b0, s[15:0]} + {13'd0, s[19:16]};
        return t[15:0] + {15'd0, t[16]};
    endfunction

endpackage

@@ sv/iuhc_stream_if.sv @@
// Channel interfaces of the checksum generator: payload, result and configuration.
interface iuhc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       last_byte;

    modport source (output valid, output payload_byte, output last_byte, input ready);
    modport sink (input valid, input payload_byte, input last_byte, output ready);
endinterface

interface iuhc_out_if;
    import iuhc_pkg::*;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] ip_total_length;
    logic [15:0]      ip_header_checksum;
    logic [LEN_W-1:0] udp_length;
    logic [15:0]      udp_checksum;
    logic             too_long;

    modport source (output valid, output ip_total_length, output ip_header_checksum,
                    output udp_length, output udp_checksum, output too_long,
                    input ready);
    modport sink (input valid, input ip_total_length, input ip_header_checksum,
                  input udp_length, input udp_checksum, input too_long,
                  output ready);
endinterface

interface iuhc_cfg_if;
    import iuhc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/iuhc_accum.sv @@
// Payload accumulator: byte pairing, running one's-complement sum and byte count.
module iuhc_accum (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic [7:0]         payload_byte,
    input  logic               last_byte,
    output iuhc_pkg::acc_fin_t fin
);
    import iuhc_pkg::*;

    logic [15:0]      running_sum_reg, running_sum_next;
    logic [7:0]       held_reg, held_next;
    logic             odd_reg, odd_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;

    logic [15:0]      sum_paired;
    logic [15:0]      sum_padded;
    logic             count_sat;
    logic [LEN_W-1:0] count_upd;
    logic             ovf_upd;

    assign sum_paired = oc_add16(running_sum_reg, {held_reg, payload_byte});
    // A final byte in the high half pairs with a zero pad.
    assign sum_padded = oc_add16(running_sum_reg, {payload_byte, 8'h00});
    assign count_sat  = (count_reg >= MAX_COUNT);
    assign count_upd  = count_sat ? count_reg : count_reg + LEN_W'(1);
    assign ovf_upd    = ovf_reg | count_sat;

    assign fin.psum     = odd_reg ? sum_paired : sum_padded;
    assign fin.count    = count_upd;
    assign fin.overflow = ovf_upd;

    always_comb
    begin
        running_sum_next = running_sum_reg;
        held_next        = held_reg;
        odd_next         = odd_reg;
        count_next       = count_reg;
        ovf_next         = ovf_reg;
        if (take)
        begin
            if (last_byte)
            begin
                running_sum_next = 16'd0;
                held_next        = 8'd0;
                odd_next         = 1'b0;
                count_next       = '0;
                ovf_next         = 1'b0;
            end
            else
            begin
                if (odd_reg)
                begin
                    running_sum_next = sum_paired;
                    odd_next         = 1'b0;
                end
                else
                begin
                    held_next = payload_byte;
                    odd_next  = 1'b1;
                end
                count_next = count_upd;
                ovf_next   = ovf_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg <= 16'd0;
            held_reg        <= 8'd0;
            odd_reg         <= 1'b0;
            count_reg       <= '0;
            ovf_reg         <= 1'b0;
        end
        else
        begin
            running_sum_reg <= running_sum_next;
            held_reg        <= held_next;
            odd_reg         <= odd_next;
            count_reg       <= count_next;
            ovf_reg         <= ovf_next;
        end
    end

endmodule

@@ sv/ipv4_udp_header_checksum_gen_unit.sv @@
// Top level of the UDP over IPv4 header length and checksum generator.
//
// Usage: UDP payload bytes enter on data_ch, one item per byte in transmit
// order, with last_byte set on the final byte of a datagram. Every byte,
// marked or not, belongs to the payload. Each marked byte yields exactly one
// item on result_ch with the IPv4 total length and header checksum, the UDP
// length and the UDP checksum over pseudo-header, UDP header and payload.
// A payload beyond 1472 bytes sets too_long and both lengths saturate.
// Throughput is one payload byte per cycle while data_ch holds ready high; the
// per-byte sum update is one 16-bit end-around-carry add in the accumulator.
// A result passes from its final byte through the accumulator summary, the partial
// sums, and fold and complement into the result register, where it can be taken.
// cfg_ch writes the address, port, ttl and ident registers by index, is
// always ready, and is to be used only while no datagram is in flight.
// Reset clears the sum state and the pipeline and loads the default
// register values. When the receiver stalls, the result register holds and
// the two stages behind it keep filling; data_ch drops ready only once all
// three hold a result.
module ipv4_udp_header_checksum_gen_unit (
    input logic         clk,
    input logic         rst_n,
    iuhc_in_if.sink     data_ch,
    iuhc_out_if.source  result_ch,
    iuhc_cfg_if.sink    cfg_ch
);
    import iuhc_pkg::*;

    // Configuration registers.
    logic [31:0] source_ip_reg;
    logic [31:0] dest_ip_reg;
    logic [15:0] source_port_reg;
    logic [15:0] dest_port_reg;
    logic [7:0]  ttl_reg;
    logic [15:0] ident_reg;

    logic     take;
    acc_fin_t fin;

    logic ready_out, ready_s2, ready_s1;
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic out_valid_reg, out_valid_next;

    acc_fin_t s1_fin_reg;

    logic [17:0]      s2_udp_a_reg;
    logic [18:0]      s2_udp_b_reg;
    logic [17:0]      s2_ip_a_reg;
    logic [17:0]      s2_ip_b_reg;
    logic [LEN_W-1:0] s2_udp_len_reg;
    logic [LEN_W-1:0] s2_ip_len_reg;
    logic             s2_ovf_reg;

    logic [LEN_W-1:0] out_ip_len_reg;
    logic [15:0]      out_ip_ck_reg;
    logic [LEN_W-1:0] out_udp_len_reg;
    logic [15:0]      out_udp_ck_reg;
    logic             out_ovf_reg;

    logic [LEN_W-1:0] udp_len;
    logic [LEN_W-1:0] ip_len;
    logic [17:0]      addr_sum;
    logic [17:0]      udp_a;
    logic [18:0]      udp_b;
    logic [17:0]      ip_a;
    logic [15:0]      udp_fold;
    logic [15:0]      ip_fold;
    logic [15:0]      udp_ck;

    // Configuration port: always ready, unknown indexes are ignored.
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_ip_reg   <= RST_SOURCE_IP;
            dest_ip_reg     <= RST_DEST_IP;
            source_port_reg <= RST_SOURCE_PORT;
            dest_port_reg   <= RST_DEST_PORT;
            ttl_reg         <= RST_TIME_TO_LIVE;
            ident_reg       <= RST_IDENT;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_SOURCE_IP:    source_ip_reg   <= cfg_ch.data;
                REG_DEST_IP:      dest_ip_reg     <= cfg_ch.data;
                REG_SOURCE_PORT:  source_port_reg <= cfg_ch.data[15:0];
                REG_DEST_PORT:    dest_port_reg   <= cfg_ch.data[15:0];
                REG_TIME_TO_LIVE: ttl_reg         <= cfg_ch.data[7:0];
                REG_IDENT:        ident_reg       <= cfg_ch.data[15:0];
                default:          ;
            endcase
        end
    end

    // Each stage loads when it is empty or the stage ahead moves on.
    assign ready_out     = !out_valid_reg || result_ch.ready;
    assign ready_s2      = !s2_valid_reg || ready_out;
    assign ready_s1      = !s1_valid_reg || ready_s2;
    assign data_ch.ready = ready_s1;
    assign take          = data_ch.valid && ready_s1;

    iuhc_accum u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .payload_byte (data_ch.payload_byte),
        .last_byte    (data_ch.last_byte),
        .fin          (fin)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take && data_ch.last_byte)
        begin
            s1_valid_next = 1'b1;
        end
        else if (ready_s2)
        begin
            s1_valid_next = 1'b0;
        end

        s2_valid_next = s2_valid_reg;
        if (ready_s2)
        begin
            s2_valid_next = s1_valid_reg;
        end

        out_valid_next = out_valid_reg;
        if (ready_out)
        begin
            out_valid_next = s2_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Partial sums. One's-complement addition is order free, so the header
    // words are gathered as plain sums and folded once at the end.
    assign udp_len  = s1_fin_reg.count + UDP_HDR_LEN;
    assign ip_len   = s1_fin_reg.count + IP_UDP_HDR_LEN;
    assign addr_sum = {2'b00, source_ip_reg[31:16]} + {2'b00, source_ip_reg[15:0]}
                    + {2'b00, dest_ip_reg[31:16]} + {2'b00, dest_ip_reg[15:0]};
    // The UDP length appears twice: once in the pseudo-header, once in the header.
    assign udp_a    = {2'b00, s1_fin_reg.psum} + {6'd0, udp_len, 1'b0}
                    + {2'b00, source_port_reg} + {2'b00, dest_port_reg};
    assign udp_b    = {1'b0, addr_sum} + {11'd0, PROTO_UDP};
    assign ip_a     = {2'b00, IP_VER_IHL_TOS} + {7'd0, ip_len} + {2'b00, ident_reg}
                    + {2'b00, ttl_reg, PROTO_UDP};

    // Fold and complement into the result register.
    assign udp_fold = fold20({2'b00, s2_udp_a_reg} + {1'b0, s2_udp_b_reg});
    assign ip_fold  = fold20({2'b00, s2_ip_a_reg} + {2'b00, s2_ip_b_reg});
    // A zero UDP checksum means no checksum on the wire, so it is sent as all ones.
    assign udp_ck   = (udp_fold == 16'hFFFF) ? 16'hFFFF : ~udp_fold;

    always_ff @(posedge clk)
    begin
        if (take && data_ch.last_byte)
        begin
            s1_fin_reg <= fin;
        end
        if (ready_s2 && s1_valid_reg)
        begin
            s2_udp_a_reg   <= udp_a;
            s2_udp_b_reg   <= udp_b;
            s2_ip_a_reg    <= ip_a;
            s2_ip_b_reg    <= addr_sum;
            s2_udp_len_reg <= udp_len;
            s2_ip_len_reg  <= ip_len;
            s2_ovf_reg     <= s1_fin_reg.overflow;
        end
        if (ready_out && s2_valid_reg)
        begin
            out_ip_len_reg  <= s2_ip_len_reg;
            out_ip_ck_reg   <= ~ip_fold;
            out_udp_len_reg <= s2_udp_len_reg;
            out_udp_ck_reg  <= udp_ck;
            out_ovf_reg     <= s2_ovf_reg;
        end
    end

    assign result_ch.valid              = out_valid_reg;
    assign result_ch.ip_total_length    = out_ip_len_reg;
    assign result_ch.ip_header_checksum = out_ip_ck_reg;
    assign result_ch.udp_length         = out_udp_len_reg;
    assign result_ch.udp_checksum       = out_udp_ck_reg;
    assign result_ch.too_long           = out_ovf_reg;

endmodule

@@ sv/iuhc_port_checker.sv @@
// Port checker of the checksum generator and its bind to the top level.
`include "ipv4_udp_header_checksum_gen_unit_assert.svh"

module iuhc_port_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   in_last,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [iuhc_pkg::LEN_W-1:0] ip_total_length,
    input logic [15:0]            ip_header_checksum,
    input logic [iuhc_pkg::LEN_W-1:0] udp_length,
    input logic [15:0]            udp_checksum,
    input logic                   too_long
);
    import iuhc_pkg::*;

    logic [2*LEN_W+32:0] out_fields;
    logic                stalled;
    logic                last_taken;
    logic                len_ok;

    assign out_fields = {ip_total_length, ip_header_checksum, udp_length, udp_checksum,
                         too_long};
    assign stalled    = out_valid && !out_ready;
    assign last_taken = in_valid && in_ready && in_last;
    assign len_ok     = (ip_total_length == udp_length + LEN_W'(IP_HDR_BYTES))
                      && (!too_long || ip_total_length == MAX_IP_LEN);

    // A stalled result holds its value.
    `IUHC_ASSERT_NEXT(a_stall_hold, clk, rst_n, stalled, out_valid && $stable(out_fields))

    // A fresh result follows a final byte that was taken before it reached the result register.
    `IUHC_ASSERT_SAME(a_result_origin, clk, rst_n, $rose(out_valid), $past(last_taken, 3))

    // The UDP checksum is never sent as zero.
    `IUHC_ASSERT_SAME(a_udp_ck_nonzero, clk, rst_n, out_valid, udp_checksum != 16'h0000)

    // The two lengths differ by the IPv4 header, and saturate together.
    `IUHC_ASSERT_SAME(a_len_relation, clk, rst_n, out_valid, len_ok)

endmodule

bind ipv4_udp_header_checksum_gen_unit iuhc_port_checker u_port_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (data_ch.valid),
    .in_ready           (data_ch.ready),
    .in_last            (data_ch.last_byte),
    .out_valid          (result_ch.valid),
    .out_ready          (result_ch.ready),
    .ip_total_length    (result_ch.ip_total_length),
    .ip_header_checksum (result_ch.ip_header_checksum),
    .udp_length         (result_ch.udp_length),
    .udp_checksum       (result_ch.udp_checksum),
    .too_long           (result_ch.too_long)
);

@@ sim/tb.sv @@
// Self-checking testbench for the UDP over IPv4 header length and checksum generator.
module tb;
    import iuhc_pkg::*;

    // Indexes that map to no register; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;

    // Least number of payload bytes queued in each phase.
    localparam int PHASE_BYTES = 16;
    localparam int PHASES      = 8;
    // Cycles waited once every result of a phase has arrived, before the next writes.
    localparam int DRAIN_CYCLES = 8;
    // Cycles without any handshake on any channel before the run is declared hung.
    localparam int QUIET_LIMIT  = 2000;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } payload_item_t;

    typedef struct packed {
        logic [LEN_W-1:0] ip_len;
        logic [15:0]      ip_ck;
        logic [LEN_W-1:0] udp_len;
        logic [15:0]      udp_ck;
        logic             too_long;
    } header_fields_t;

    logic clk;
    logic rst_n;

    iuhc_in_if  data_ch();
    iuhc_out_if result_ch();
    iuhc_cfg_if cfg_ch();

    ipv4_udp_header_checksum_gen_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_ch   (data_ch),
        .result_ch (result_ch),
        .cfg_ch    (cfg_ch)
    );

    // Payload bytes waiting to be driven, and the headers we expect back.
    payload_item_t  pending_bytes[$];
    header_fields_t expected_headers[$];

    int queued_count   = 0;
    int accepted_count = 0;
    int error_count    = 0;
    int quiet_cycles   = 0;

    // Idle probabilities in percent, changed between phases.
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // Set at each rising edge when the byte on data_ch was taken.
    logic byte_taken = 1'b0;

    // Our own copy of the configuration registers, starting at the reset values.
    logic [31:0] cfg_src_ip   = RST_SOURCE_IP;
    logic [31:0] cfg_dst_ip   = RST_DEST_IP;
    logic [15:0] cfg_src_port = RST_SOURCE_PORT;
    logic [15:0] cfg_dst_port = RST_DEST_PORT;
    logic [7:0]  cfg_ttl      = RST_TIME_TO_LIVE;
    logic [15:0] cfg_ident    = RST_IDENT;

    // Per-datagram accumulation state of the predictor.
    logic [15:0]      word_sum    = '0;
    logic [7:0]       high_byte   = '0;
    logic             odd_byte    = 1'b0;
    logic [LEN_W-1:0] payload_len = '0;
    logic             saturated   = 1'b0;

    always #5 clk = ~clk;

    // 16-bit one's-complement add: the carry out of bit 15 wraps into bit 0.
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[15:0] + 16'(t[16]);
    endfunction

    // Both addresses appear in the IP header and in the UDP pseudo-header.
    function automatic logic [15:0] add_addresses(input logic [15:0] start);
        logic [15:0] s;
        s = ones_add(start, cfg_src_ip[31:16]);
        s = ones_add(s, cfg_src_ip[15:0]);
        s = ones_add(s, cfg_dst_ip[31:16]);
        return ones_add(s, cfg_dst_ip[15:0]);
    endfunction

    // Adds the pseudo-header and the UDP header (with a zero checksum field) to a payload sum.
    // The UDP length shows up twice: once in the pseudo-header and once in the UDP header.
    function automatic logic [15:0] udp_sum(input logic [15:0] start,
                                            input logic [LEN_W-1:0] ulen);
        logic [15:0] s;
        s = add_addresses(start);
        s = ones_add(s, 16'(PROTO_UDP));
        s = ones_add(s, 16'(ulen));
        s = ones_add(s, cfg_src_port);
        s = ones_add(s, cfg_dst_port);
        return ones_add(s, 16'(ulen));
    endfunction

    // Folds one accepted payload byte into the running state. On the final byte the
    // expected header fields are computed and the state clears for the next datagram.
    task automatic absorb_byte(input logic [7:0] b, input logic last);
        header_fields_t   hdr;
        logic [15:0]      s;
        logic [LEN_W-1:0] ulen;
        logic [LEN_W-1:0] ilen;
        // Bytes pair up big-endian; the first byte of a pair waits as the high half.
        if (odd_byte)
        begin
            word_sum = ones_add(word_sum, {high_byte, b});
            odd_byte = 1'b0;
        end
        else
        begin
            high_byte = b;
            odd_byte  = 1'b1;
        end
        // The length stops at the maximum; any byte past it marks the datagram too long,
        // while the sum above still takes every byte.
        if (payload_len >= MAX_COUNT)
            saturated = 1'b1;
        else
            payload_len = payload_len + 1'b1;

        if (last)
        begin
            s = word_sum;
            // An odd final byte is summed with a zero pad as its low half.
            if (odd_byte)
                s = ones_add(s, {high_byte, 8'h00});
            ulen = payload_len + UDP_HDR_LEN;
            ilen = payload_len + IP_UDP_HDR_LEN;

            s = udp_sum(s, ulen);
            hdr.udp_ck = ~s;
            // A zero UDP checksum means "none" on the wire, so it is sent as all ones.
            if (hdr.udp_ck == 16'h0000)
                hdr.udp_ck = 16'hFFFF;

            // IP header: version/length/tos, total length, ident, flags/offset of zero,
            // ttl with protocol, zero checksum field, then both addresses.
            s = ones_add(IP_VER_IHL_TOS, 16'(ilen));
            s = ones_add(s, cfg_ident);
            s = ones_add(s, {cfg_ttl, PROTO_UDP});
            s = add_addresses(s);
            hdr.ip_ck    = ~s;
            hdr.ip_len   = ilen;
            hdr.udp_len  = ulen;
            hdr.too_long = saturated;
            expected_headers.push_back(hdr);

            word_sum    = '0;
            high_byte   = '0;
            odd_byte    = 1'b0;
            payload_len = '0;
            saturated   = 1'b0;
        end
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic last);
        pending_bytes.push_back('{value: b, last: last});
        queued_count++;
    endtask

    // Queues one datagram of random content. Bytes lean toward all zeros and
    // all ones now and then so that carry folding is exercised hard.
    task automatic queue_datagram(input int len);
        int          i;
        int          pick;
        logic [7:0]  b;
        for (i = 0; i < len; i++)
        begin
            pick = $urandom_range(9);
            if (pick == 0)
                b = 8'h00;
            else if (pick == 1)
                b = 8'hFF;
            else
                b = 8'($urandom_range(255));
            queue_byte(b, i == len - 1);
        end
    endtask

    // Builds a two-byte payload whose word cancels the rest of the UDP sum under the
    // present configuration, so the computed checksum comes out as zero.
    task automatic queue_zero_checksum_datagram();
        logic [15:0] w;
        w = ~udp_sum(16'h0000, UDP_HDR_LEN + 11'd2);
        queue_byte(w[15:8], 1'b0);
        queue_byte(w[7:0], 1'b1);
    endtask

    // One register write; the caller stands at a falling edge, and so does the task
    // when it returns. The caller lowers valid after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
    endtask

    // Writes every register and both unused indexes. The narrow registers get the full
    // 32-bit word, so the bits above their width must be dropped by the block.
    task automatic program_regs(input logic [31:0] sip, input logic [31:0] dip,
                                input logic [31:0] sport, input logic [31:0] dport,
                                input logic [31:0] ttl, input logic [31:0] id);
        write_reg(REG_SOURCE_IP, sip);
        write_reg(REG_UNUSED_A, 32'($urandom));
        write_reg(REG_DEST_IP, dip);
        write_reg(REG_SOURCE_PORT, sport);
        write_reg(REG_DEST_PORT, dport);
        write_reg(REG_UNUSED_B, 32'($urandom));
        write_reg(REG_TIME_TO_LIVE, ttl);
        write_reg(REG_IDENT, id);
        cfg_ch.valid <= 1'b0;
    endtask

    // Blocks until every queued byte was taken and every expected header arrived,
    // then lets the pipeline settle so that the block is idle for the next writes.
    task automatic drain();
        while (accepted_count != queued_count || expected_headers.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Byte driver: a byte stays on the channel until taken, then the next one from the
    // queue follows at once or after a random idle gap.
    always @(negedge clk)
    begin : byte_driver
        payload_item_t nxt;
        if (!rst_n)
        begin
            data_ch.valid <= 1'b0;
        end
        else if (!data_ch.valid || byte_taken)
        begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pending_bytes.pop_front();
                data_ch.valid        <= 1'b1;
                data_ch.payload_byte <= nxt.value;
                data_ch.last_byte    <= nxt.last;
            end
            else
            begin
                data_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure: ready is drawn afresh every cycle.
    always @(negedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Monitor: predicts on every accepted byte, follows register writes, checks every
    // accepted result against the oldest expectation, and watches for a hang.
    always @(posedge clk)
    begin : monitor
        header_fields_t exp_hdr;
        logic           any_handshake;
        any_handshake = 1'b0;
        byte_taken <= data_ch.valid && data_ch.ready;

        if (rst_n && cfg_ch.valid && cfg_ch.ready)
        begin
            any_handshake = 1'b1;
            case (cfg_ch.index)
                REG_SOURCE_IP:    cfg_src_ip   = cfg_ch.data;
                REG_DEST_IP:      cfg_dst_ip   = cfg_ch.data;
                REG_SOURCE_PORT:  cfg_src_port = cfg_ch.data[15:0];
                REG_DEST_PORT:    cfg_dst_port = cfg_ch.data[15:0];
                REG_TIME_TO_LIVE: cfg_ttl      = cfg_ch.data[7:0];
                REG_IDENT:        cfg_ident    = cfg_ch.data[15:0];
                default:          ;
            endcase
        end

        if (rst_n && data_ch.valid && data_ch.ready)
        begin
            any_handshake = 1'b1;
            accepted_count++;
            absorb_byte(data_ch.payload_byte, data_ch.last_byte);
        end

        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            any_handshake = 1'b1;
            if (expected_headers.size() == 0)
            begin
                $error("result item arrived with no datagram pending");
                error_count++;
            end
            else
            begin
                exp_hdr = expected_headers.pop_front();
                if (result_ch.ip_total_length !== exp_hdr.ip_len)
                begin
                    $error("ip_total_length: expected %0d, got %0d",
                           exp_hdr.ip_len, result_ch.ip_total_length);
                    error_count++;
                end
                if (result_ch.ip_header_checksum !== exp_hdr.ip_ck)
                begin
                    $error("ip_header_checksum: expected %h, got %h",
                           exp_hdr.ip_ck, result_ch.ip_header_checksum);
                    error_count++;
                end
                if (result_ch.udp_length !== exp_hdr.udp_len)
                begin
                    $error("udp_length: expected %0d, got %0d",
                           exp_hdr.udp_len, result_ch.udp_length);
                    error_count++;
                end
                if (result_ch.udp_checksum !== exp_hdr.udp_ck)
                begin
                    $error("udp_checksum: expected %h, got %h",
                           exp_hdr.udp_ck, result_ch.udp_checksum);
                    error_count++;
                end
                if (result_ch.too_long !== exp_hdr.too_long)
                begin
                    $error("too_long: expected %b, got %b",
                           exp_hdr.too_long, result_ch.too_long);
                    error_count++;
                end
            end
        end

        // Any handshake shows progress; a long silence means the block is stuck or a
        // result never came.
        if (any_handshake)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus sequencer: reset, a short directed opening, then phases that each set a
    // configuration and an idling pattern and stream random datagrams.
    initial
    begin : sequencer
        int phase;
        int phase_start;
        int len_pick;
        clk                  = 1'b0;
        rst_n                = 1'b0;
        data_ch.valid        = 1'b0;
        data_ch.payload_byte = 8'h00;
        data_ch.last_byte    = 1'b0;
        result_ch.ready      = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = REG_SOURCE_IP;
        cfg_ch.data          = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (phase = 0; phase < PHASES; phase++)
        begin
            // Phase 0 runs on the reset values; the next two take the register extremes.
            if (phase == 1)
                program_regs(32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                             32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
            else if (phase == 2)
                program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            else if (phase > 2)
                program_regs(32'($urandom), 32'($urandom), 32'($urandom),
                             32'($urandom), 32'($urandom), 32'($urandom));

            // Idling pattern: none, sender gaps, receiver stalls, then both.
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 52;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 52;
                end
                default:
                begin
                    send_idle_pct = 24;
                    stall_pct     = 24;
                end
            endcase

            phase_start = queued_count;

            if (phase == 0)
            begin
                // Single-byte datagrams at both byte extremes.
                queue_byte(8'h00, 1'b1);
                queue_byte(8'hFF, 1'b1);
                // A full all-ones word, which forces an end-around carry.
                queue_byte(8'hFF, 1'b0);
                queue_byte(8'hFF, 1'b1);
                // Odd lengths: the final byte is padded with a zero low half.
                queue_byte(8'h12, 1'b0);
                queue_byte(8'h34, 1'b0);
                queue_byte(8'h56, 1'b1);
                queue_byte(8'h80, 1'b0);
                queue_byte(8'h01, 1'b0);
                queue_byte(8'h7F, 1'b0);
                queue_byte(8'hFE, 1'b0);
                queue_byte(8'h00, 1'b1);
            end

            // A computed UDP checksum of zero must go out as all ones, under every setting.
            queue_zero_checksum_datagram();

            // One byte past the longest payload that fits: the length stops at the
            // maximum and the datagram is marked too long.
            if (phase == 5)
                queue_datagram(MAX_PAYLOAD + 1);

            // Random datagrams: mostly short ones so that many results come back.
            while (queued_count - phase_start < PHASE_BYTES)
            begin
                len_pick = $urandom_range(99);
                if (len_pick < 80)
                    queue_datagram($urandom_range(1, 16));
                else if (len_pick < 95)
                    queue_datagram($urandom_range(17, 64));
                else
                    queue_datagram($urandom_range(65, 300));
            end

            drain();
        end

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/iuhc_pkg.sv
sv/iuhc_stream_if.sv
sv/iuhc_accum.sv
sv/ipv4_udp_header_checksum_gen_unit.sv
sv/iuhc_port_checker.sv
sim/tb.sv
